// ----- hdl/mh128_pkg.sv -----
package mh128_pkg;

	typedef logic [31:0] word_t;
	typedef word_t [3:0] mix_t;

	// Opcode of an input transaction.
	localparam logic OP_START = 1'b0;
	localparam logic OP_DATA  = 1'b1;

	// Seeds of the four mixing words.
	localparam word_t SEED0 = 32'd1831565813;
	localparam word_t SEED1 = 32'd461845907;
	localparam word_t SEED2 = 32'd2246822507;
	localparam word_t SEED3 = 32'd3266489909;

	// Request from the absorb stage to the finalization stage.
	typedef struct packed {
		logic  valid;
		mix_t  mix;
		word_t len;
	} fin_req_t;

	// Rotate left by a constant amount between 1 and 31.
	function automatic word_t rotl32(input word_t v, input int unsigned n);
		return (v << n) | (v >> (32 - n));
	endfunction

endpackage

// ----- hdl/mh128_if.sv -----
interface mh128_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] message_length;
	logic [7:0]  data_byte;

	modport source (output valid, output opcode, output message_length, output data_byte,
		input ready);
	modport sink (input valid, input opcode, input message_length, input data_byte,
		output ready);
endinterface

interface mh128_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [1:0]  word_index;
	logic        last_word;

	modport source (output valid, output digest_word, output word_index, output last_word,
		input ready);
	modport sink (input valid, input digest_word, input word_index, input last_word,
		output ready);
endinterface

// ----- hdl/mh128_absorb.sv -----
module mh128_absorb (
	input  logic                clk,
	input  logic                arst_n,
	mh128_in_if.sink            item,
	output mh128_pkg::fin_req_t fin_req,
	input  logic                fin_ready
);
	import mh128_pkg::*;

	logic        valid_s1;
	logic        op_s1;
	word_t       len_s1;
	logic [7:0]  byte_s1;

	mix_t        mix_q;
	logic [7:0]  blk_q [7];
	word_t       cnt_q;
	word_t       exp_q;
	logic        open_q;

	word_t       cnt_inc;
	logic        is_start;
	logic        is_data;
	logic        do_absorb;
	logic        fin;
	logic        adv;
	word_t       v0;
	word_t       v1;
	mix_t        seed_mix;
	mix_t        abs_mix;

	always_comb begin
		cnt_inc   = cnt_q + 32'd1;
		is_start  = (op_s1 == OP_START);
		is_data   = (op_s1 == OP_DATA) && open_q;
		do_absorb = is_data && (cnt_inc[2:0] == 3'd0);
		fin       = valid_s1 && (is_start ? (len_s1 == 32'd0) : (is_data && cnt_inc == exp_q));
		adv       = !fin || fin_ready;

		v0 = {blk_q[3], blk_q[2], blk_q[1], blk_q[0]};
		v1 = {byte_s1, blk_q[6], blk_q[5], blk_q[4]};

		seed_mix[0] = SEED0 ^ len_s1;
		seed_mix[1] = SEED1 ^ (len_s1 << 8);
		seed_mix[2] = SEED2 ^ (len_s1 << 16);
		seed_mix[3] = SEED3 ^ (len_s1 << 24);

		abs_mix[0] = rotl32((mix_q[0] + v0) ^ mix_q[2], 7);
		abs_mix[1] = rotl32((v0 ^ mix_q[1]) + mix_q[3], 11);
		abs_mix[2] = rotl32((mix_q[2] + v1) ^ abs_mix[0], 13);
		abs_mix[3] = rotl32((mix_q[3] ^ v1) + abs_mix[1], 17);

		fin_req.valid = fin;
		fin_req.mix   = is_start ? seed_mix : (do_absorb ? abs_mix : mix_q);
		fin_req.len   = is_start ? len_s1 : exp_q;
	end

	assign item.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			op_s1   <= item.opcode;
			len_s1  <= item.message_length;
			byte_s1 <= item.data_byte;
		end
	end

	// The eighth byte of a block is used straight from the input register.
	always_ff @(posedge clk) begin
		if (valid_s1 && adv && is_data && cnt_q[2:0] != 3'd7) begin
			blk_q[cnt_q[2:0]] <= byte_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mix_q  <= '0;
			cnt_q  <= '0;
			exp_q  <= '0;
			open_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			if (is_start) begin
				mix_q  <= seed_mix;
				exp_q  <= len_s1;
				cnt_q  <= '0;
				open_q <= (len_s1 != 32'd0);
			end else if (is_data) begin
				cnt_q <= cnt_inc;
				if (do_absorb) begin
					mix_q <= abs_mix;
				end
				if (cnt_inc == exp_q) begin
					open_q <= 1'b0;
				end
			end
		end
	end

	a_zero_len_fin: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && op_s1 == OP_START && len_s1 == 32'd0 |-> fin_req.valid)
		else $error("zero length start did not request finalization");

	a_block_stall: assert property (@(posedge clk) disable iff (!arst_n)
		fin_req.valid && !fin_ready |-> !item.ready)
		else $error("input taken while finalization request is blocked");

	a_open_len: assert property (@(posedge clk) disable iff (!arst_n)
		open_q |-> exp_q != 32'd0 && cnt_q != exp_q)
		else $error("open message with inconsistent byte count");

endmodule

// ----- hdl/mh128_final.sv -----
module mh128_final (
	input  logic                clk,
	input  logic                arst_n,
	input  mh128_pkg::fin_req_t fin_req,
	output logic                fin_ready,
	mh128_out_if.source         result
);
	import mh128_pkg::*;

	logic        fin_valid_s2;
	mix_t        mix_s2;
	word_t       len_s2;

	mix_t        digest_q;
	logic        out_valid_q;
	logic [1:0]  idx_q;

	mix_t        d;
	word_t       t0;
	word_t       t1;
	word_t       t2;
	word_t       t3;
	logic        buf_free;
	logic        load;

	always_comb begin
		t0   = mix_s2[0] ^ len_s2;
		t1   = mix_s2[1] ^ t0;
		t2   = mix_s2[2] + t1;
		t3   = mix_s2[3] ^ t2;
		d[0] = rotl32(t0, 9) + rotl32(t2, 17);
		d[1] = rotl32(t1, 13) ^ rotl32(t3, 19);
		d[2] = rotl32(t2, 17) + d[0];
		d[3] = rotl32(t3, 19) ^ d[1];
	end

	assign buf_free  = !out_valid_q || (result.ready && idx_q == 2'd3);
	assign load      = fin_valid_s2 && buf_free;
	assign fin_ready = !fin_valid_s2 || buf_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_valid_s2 <= 1'b0;
		end else if (fin_req.valid && fin_ready) begin
			fin_valid_s2 <= 1'b1;
		end else if (load) begin
			fin_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_req.valid && fin_ready) begin
			mix_s2 <= fin_req.mix;
			len_s2 <= fin_req.len;
		end
		if (load) begin
			digest_q <= d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= 1'b1;
			idx_q       <= '0;
		end else if (out_valid_q && result.ready) begin
			idx_q <= idx_q + 2'd1;
			if (idx_q == 2'd3) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result.valid       = out_valid_q;
	assign result.digest_word = digest_q[idx_q];
	assign result.word_index  = idx_q;
	assign result.last_word   = (idx_q == 2'd3);

	a_words_follow: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last_word |=> result.valid)
		else $error("digest ended before its fourth word");

	a_index_step: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.ready && !result.last_word
		|=> result.word_index == 2'($past(result.word_index) + 2'd1))
		else $error("digest word index skipped");

	a_req_taken: assert property (@(posedge clk) disable iff (!arst_n)
		fin_req.valid && fin_ready |=> fin_valid_s2)
		else $error("finalization request lost");

endmodule

// ----- hdl/mix_hash_128_stream_unit.sv -----
// Channel  Role    Payload                                   Transaction when
// item     sink    opcode, message_length, data_byte         item.valid & item.ready
// result   source  digest_word, word_index, last_word        result.valid & result.ready
//
// An input transaction is taken every cycle while item.ready is high; the absorb stage
// works from its input register, and a finished message passes the finalization and
// digest registers; each digest gives four words, one word per cycle while result.ready
// is high, so input stalls only when a third finished message meets two queued digests.
// Reset (arst_n, asynchronous, active low) clears every valid flag and the hash state.
// Stalls on the result side propagate back through ready; nothing is dropped.
module mix_hash_128_stream_unit (
	input  logic        clk,
	input  logic        arst_n,
	mh128_in_if.sink    item,
	mh128_out_if.source result
);
	import mh128_pkg::*;

	// Finalization request between the absorb stage and the output stage.
	fin_req_t fin_req;
	logic     fin_ready;

	// The absorb stage holds the input register and the running hash state. The first seven
	// bytes of a block are stored, and the four rotate-add-xor updates run in the same
	// cycle as the eighth byte.
	mh128_absorb u_absorb (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.fin_req   (fin_req),
		.fin_ready (fin_ready)
	);

	// The output stage registers the mixing words of a finished message, runs the
	// finalization mix and streams the four digest words, word 0 first.
	mh128_final u_final (
		.clk       (clk),
		.arst_n    (arst_n),
		.fin_req   (fin_req),
		.fin_ready (fin_ready),
		.result    (result)
	);

endmodule
